/* rtl/core/ris_pkg.sv */
// ris_pkg: shared types, constants and register indexes of the
// reprojection inlier scoring core. No dependencies.
package ris_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned ERR_W = 48;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned QUOT_W = 41;
  localparam int unsigned DIV_STEPS = 21;

  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};
  localparam logic [QUOT_W-1:0] QUOT_LIMIT = {1'b1, {(QUOT_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POINT = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X  = 3'd0,
    CFG_FOCAL_Y  = 3'd1,
    CFG_CENTER_X = 3'd2,
    CFG_CENTER_Y = 3'd3,
    CFG_ERR_LIM  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_CHECK,
    ST_PMUL,
    ST_PLOAD,
    ST_PDIV,
    ST_SQ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [30:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/core/ris_if.sv */
// ris_if: valid/ready channel interfaces for point/load words and results.
// No dependencies.
interface ris_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [3:0]         pose_index;
  logic signed [31:0] pose_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] image_u;
  logic signed [31:0] image_v;
  logic               last_point;

  modport source (output valid, operation, pose_index, pose_value, point_x, point_y,
                  point_z, image_u, image_v, last_point, input ready);
  modport sink (input valid, operation, pose_index, pose_value, point_x, point_y,
                point_z, image_u, image_v, last_point, output ready);
endinterface

interface ris_out_if;
  logic        valid;
  logic        ready;
  logic        is_inlier;
  logic [47:0] error_sq;
  logic [10:0] inlier_total;
  logic        last_result;

  modport source (output valid, is_inlier, error_sq, inlier_total, last_result,
                  input ready);
  modport sink (input valid, is_inlier, error_sq, inlier_total, last_result,
                output ready);
endinterface

/* rtl/core/ris_mul.sv */
// ris_mul: shared 33x33 signed multiplier with registered product.
// Depends on ris_pkg.
module ris_mul
  import ris_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

/* rtl/core/ris_div.sv */
// ris_div: radix-4 restoring divider, 64-bit dividend over 31-bit divisor,
// quotient limited to QUOT_LIMIT. Depends on ris_pkg.
module ris_div
  import ris_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned CW = $clog2(DIV_STEPS);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [30:0]   den_r, den_nxt;
  logic [30:0]   rem_r, rem_nxt;
  logic [41:0]   sh_r, sh_nxt;
  logic [41:0]   q_r, q_nxt;
  logic [QUOT_W-1:0] quot_r, quot_nxt;
  logic [31:0]   t1, t2;
  logic [30:0]   r1, r2;
  logic          b1, b2;
  logic [41:0]   q_full;

  always_comb begin
    t1 = {rem_r, sh_r[41]};
    b1 = (t1 >= {1'b0, den_r});
    r1 = b1 ? 31'(t1 - {1'b0, den_r}) : t1[30:0];
    t2 = {r1, sh_r[40]};
    b2 = (t2 >= {1'b0, den_r});
    r2 = b2 ? 31'(t2 - {1'b0, den_r}) : t2[30:0];
    q_full = {q_r[39:0], b1, b2};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    quot_nxt = quot_r;
    if (req.start) begin
      den_nxt = req.den;
      cnt_nxt = '0;
      q_nxt   = '0;
      sh_nxt  = req.num[41:0];
      rem_nxt = {9'd0, req.num[63:42]};
      if ({9'd0, req.num[63:42]} >= req.den) begin
        // quotient at least 2^42, clamp at once
        quot_nxt = QUOT_LIMIT;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = r2;
      sh_nxt  = {sh_r[39:0], 2'b00};
      q_nxt   = q_full;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        quot_nxt = (q_full > {1'b0, QUOT_LIMIT}) ? QUOT_LIMIT : q_full[QUOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    q_r    <= q_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

/* rtl/core/reprojection_inlier_scoring_core.sv */
// reprojection_inlier_scoring_core: scores 3D-2D matches against a pinhole pose.
// Depends on ris_pkg, ris_if, ris_mul, ris_div.
//
//   channel  dir  handshake        contents
//   in_ch    in   valid/ready      pose load word or point word
//   out_ch   out  valid/ready      inlier flag, squared error, count, last
//   cfg_*    in   cfg_we only      focal, center, error limit registers
//
// a pose load leaves the core ready in the next cycle; a point holds the core
// through rotation and depth check, and when its depth is positive through the
// shared radix-4 divider (21 iterations per axis, fewer when a quotient clamps at once)
// and the single multiplier. one point is in flight at a time; a result not yet taken
// holds ST_OUT, and the result register lets the next word in while a result waits.
// rst_n is synchronous and clears pose, count, registers.
module reprojection_inlier_scoring_core
  import ris_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ris_in_if.sink                in_ch,
  ris_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CAP_I = (MAX_POINTS < 2047) ? MAX_POINTS : 2047;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_I);

  state_t state_r, state_nxt;

  logic [31:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [ERR_W-1:0] err_lim_r;
  logic signed [31:0] rot_r [9];
  logic signed [31:0] trans_r [3];

  logic signed [31:0] pt_r [3];
  logic signed [31:0] img_r [2];
  logic               last_r;
  logic signed [31:0] cam_r [3];
  logic signed [49:0] acc_r;
  logic               iss_r;
  logic [1:0]         row_r, col_r;
  logic               pv_r;
  logic [1:0]         prow_r, pcol_r;
  logic               axis_r;
  logic [43:0]        m_r [2];
  logic               big_r [2];
  logic [1:0]         sq_r;
  logic [ERR_W:0]     term_r;
  logic [ERR_W-1:0]   err_r;
  logic               zpos_r;
  logic [CNT_W-1:0]   cnt_r;

  logic               out_vld_r;
  logic               out_inl_r;
  logic [ERR_W-1:0]   out_err_r;
  logic [CNT_W-1:0]   out_tot_r;
  logic               out_last_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  div_req_t           dreq;
  div_rsp_t           drsp;

  logic               in_acc;
  logic               out_free;
  logic [3:0]         rot_idx;
  logic signed [49:0] prod_sh, acc_sum;
  logic signed [31:0] acc_sat;
  logic signed [31:0] cam_ax;
  logic [31:0]        mag_ax;
  logic signed [44:0] proj, dval;
  logic [43:0]        dmag;
  logic [ERR_W:0]     term_now;
  logic [ERR_W+1:0]   err_sum;
  logic               inl;
  logic [CNT_W-1:0]   cnt_inc;

  ris_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));
  ris_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_vld_r || out_ch.ready;
  assign rot_idx  = 4'({row_r, 1'b0}) + 4'(row_r) + 4'(col_r);
  assign cam_ax   = axis_r ? cam_r[1] : cam_r[0];
  assign mag_ax   = cam_ax[31] ? 32'(-33'(cam_ax)) : 32'(cam_ax);

  // product accumulate into camera coordinate
  always_comb begin
    prod_sh = mul_p[65:16];
    acc_sum = (pcol_r == 2'd0) ? 50'(trans_r[prow_r]) + prod_sh : acc_r + prod_sh;
    if (acc_sum > 50'sd2147483647) begin
      acc_sat = 32'sh7fffffff;
    end else if (acc_sum < -50'sd2147483648) begin
      acc_sat = 32'sh80000000;
    end else begin
      acc_sat = acc_sum[31:0];
    end
  end

  // projection and pixel difference after divide
  always_comb begin
    proj = cam_ax[31] ? -45'(drsp.quot) : 45'(drsp.quot);
    proj = proj + 45'(center_x_r);
    if (axis_r) begin
      proj = (cam_ax[31] ? -45'(drsp.quot) : 45'(drsp.quot)) + 45'(center_y_r);
      dval = 45'(img_r[1]) - proj;
    end else begin
      dval = 45'(img_r[0]) - proj;
    end
    dmag = dval[44] ? 44'(-dval) : 44'(dval);
  end

  always_comb begin
    term_now = (sq_r == 2'd1) ? (big_r[0] ? {1'b1, {ERR_W{1'b0}}} : {1'b0, mul_p[63:16]})
                              : (big_r[1] ? {1'b1, {ERR_W{1'b0}}} : {1'b0, mul_p[63:16]});
    err_sum  = {1'b0, term_r} + {1'b0, term_now};
    inl      = zpos_r && (err_r <= err_lim_r);
    cnt_inc  = (inl && cnt_r < COUNT_CAP) ? cnt_r + 1'b1 : cnt_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && in_ch.operation == OP_POINT) state_nxt = ST_ROT;
      ST_ROT:   if (pv_r && prow_r == 2'd2 && pcol_r == 2'd2) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = (cam_r[2] > 32'sd0) ? ST_PMUL : ST_OUT;
      ST_PMUL:  state_nxt = ST_PLOAD;
      ST_PLOAD: state_nxt = ST_PDIV;
      ST_PDIV:  if (drsp.done) state_nxt = axis_r ? ST_SQ : ST_PMUL;
      ST_SQ:    if (sq_r == 2'd2) state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    mul_a       = '0;
    mul_b       = '0;
    dreq.start  = 1'b0;
    dreq.num    = mul_p[63:0];
    dreq.den    = cam_r[2][30:0];
    unique case (state_r)
      ST_ROT: begin
        if (iss_r) begin
          mul_a = 33'(rot_r[rot_idx]);
          mul_b = 33'(pt_r[col_r]);
        end
      end
      ST_PMUL: begin
        mul_a = {1'b0, mag_ax};
        mul_b = {1'b0, axis_r ? focal_y_r : focal_x_r};
      end
      ST_PLOAD: dreq.start = 1'b1;
      ST_SQ: begin
        mul_a = (sq_r == 2'd0) ? {1'b0, m_r[0][31:0]} : {1'b0, m_r[1][31:0]};
        mul_b = mul_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      focal_x_r  <= '0;
      focal_y_r  <= '0;
      center_x_r <= '0;
      center_y_r <= '0;
      err_lim_r  <= '0;
      for (int i = 0; i < 9; i++) rot_r[i] <= '0;
      for (int i = 0; i < 3; i++) trans_r[i] <= '0;
      cnt_r      <= '0;
      out_vld_r  <= 1'b0;
      iss_r      <= 1'b0;
      pv_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FOCAL_X:  focal_x_r  <= cfg_data[31:0];
          CFG_FOCAL_Y:  focal_y_r  <= cfg_data[31:0];
          CFG_CENTER_X: center_x_r <= cfg_data[31:0];
          CFG_CENTER_Y: center_y_r <= cfg_data[31:0];
          CFG_ERR_LIM:  err_lim_r  <= cfg_data[ERR_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && in_ch.operation == OP_LOAD) begin
        if (in_ch.pose_index < 4'd9) begin
          rot_r[in_ch.pose_index] <= in_ch.pose_value;
        end else if (in_ch.pose_index < 4'd12) begin
          trans_r[2'(in_ch.pose_index - 4'd9)] <= in_ch.pose_value;
        end
      end
      if (in_acc) begin
        iss_r <= (in_ch.operation == OP_POINT);
      end else if (state_r == ST_ROT && row_r == 2'd2 && col_r == 2'd2) begin
        iss_r <= 1'b0;
      end
      pv_r <= (state_r == ST_ROT) && iss_r;
      if (state_r == ST_OUT && out_free) begin
        out_vld_r <= 1'b1;
        cnt_r     <= last_r ? '0 : cnt_inc;
      end else if (out_vld_r && out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pt_r[0]  <= in_ch.point_x;
      pt_r[1]  <= in_ch.point_y;
      pt_r[2]  <= in_ch.point_z;
      img_r[0] <= in_ch.image_u;
      img_r[1] <= in_ch.image_v;
      last_r   <= in_ch.last_point;
      row_r    <= '0;
      col_r    <= '0;
      axis_r   <= 1'b0;
      sq_r     <= '0;
    end
    if (state_r == ST_ROT && iss_r) begin
      col_r <= (col_r == 2'd2) ? 2'd0 : col_r + 2'd1;
      if (col_r == 2'd2) row_r <= row_r + 2'd1;
    end
    prow_r <= row_r;
    pcol_r <= col_r;
    if (pv_r) begin
      acc_r <= acc_sum;
      if (pcol_r == 2'd2) cam_r[prow_r] <= acc_sat;
    end
    if (state_r == ST_CHECK) begin
      zpos_r <= (cam_r[2] > 32'sd0);
      err_r  <= ERR_MAX;
    end
    if (state_r == ST_PDIV && drsp.done) begin
      m_r[axis_r]   <= dmag;
      big_r[axis_r] <= |dmag[43:32];
      axis_r        <= 1'b1;
    end
    if (state_r == ST_SQ) begin
      sq_r <= sq_r + 2'd1;
      if (sq_r == 2'd1) term_r <= term_now;
      if (sq_r == 2'd2) err_r <= err_sum[ERR_W+1:ERR_W] != 2'b00 ? ERR_MAX : err_sum[ERR_W-1:0];
    end
    if (state_r == ST_OUT && out_free) begin
      out_inl_r  <= inl;
      out_err_r  <= err_r;
      out_tot_r  <= cnt_inc;
      out_last_r <= last_r;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.is_inlier    = out_inl_r;
  assign out_ch.error_sq     = out_err_r;
  assign out_ch.inlier_total = out_tot_r;
  assign out_ch.last_result  = out_last_r;

endmodule

/* rtl/core/ris_chk.sv */
// ris_chk: port-level assertions for the scoring core, bound to the top level.
// Depends on ris_pkg.
module ris_chk
  import ris_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_inlier,
  input logic [10:0] out_inlier_total
);

  // a result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before taken");

  // a point word keeps the core busy the next cycle
  a_point_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_POINT |=> !in_ready)
    else $error("core ready right after point word");

  // a pose load word leaves the core ready in the next cycle
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_LOAD |=> in_ready)
    else $error("core stalled after pose load word");

  // an inlier is always counted
  a_inlier_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_inlier |-> out_inlier_total != 11'd0)
    else $error("inlier with zero count");

endmodule

bind reprojection_inlier_scoring_core ris_chk u_ris_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_operation     (in_ch.operation),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_is_inlier    (out_ch.is_inlier),
  .out_inlier_total (out_ch.inlier_total)
);

/* sim/tb_reprojection_inlier_scoring_core.sv */
// tb_reprojection_inlier_scoring_core: self-checking bench for the reprojection
// inlier scoring core, with a fixed-point score predictor and random pose/point traffic.
// Depends on ris_pkg, ris_if and the core RTL.
module tb_reprojection_inlier_scoring_core;
  import ris_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_CAP  = (MAX_POINTS_DEF < 2047) ? MAX_POINTS_DEF : 2047;
  localparam int unsigned STALL_MAX  = 5000;
  localparam int unsigned DRAIN_CYC  = 100;
  localparam longint      ONE        = 64'sh10000;

  typedef struct {
    op_t                op;
    logic [3:0]         idx;
    logic signed [31:0] pv, px, py, pz, u, v;
    logic               last;
  } word_t;

  typedef struct {
    logic        is_inlier;
    logic [47:0] error_sq;
    logic [10:0] inlier_total;
    logic        last_result;
  } score_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ris_in_if  in_ch ();
  ris_out_if out_ch ();

  reprojection_inlier_scoring_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  longint      rot [9];
  longint      trn [3];
  int unsigned inl_cnt;
  logic [31:0] fx, fy, cx, cy;
  logic [47:0] err_lim;

  score_t expected_scores [$];
  int     fails = 0;
  bit     calm = 1'b0;
  int unsigned quiet_cycles = 0;

  function automatic longint cam_row(int r, longint p0, longint p1, longint p2);
    longint s;
    s = trn[r] + ((rot[r*3] * p0) >>> 16) + ((rot[r*3+1] * p1) >>> 16)
        + ((rot[r*3+2] * p2) >>> 16);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  function automatic longint project(longint c, logic [31:0] f, longint z, logic [31:0] ctr);
    logic [63:0] mag, q;
    mag = (c < 0) ? 64'(-c) : 64'(c);
    q = (mag * {32'd0, f}) / 64'(z);
    if (q > 64'h100_0000_0000) q = 64'h100_0000_0000;
    return ((c < 0) ? -longint'(q) : longint'(q)) + longint'({32'd0, ctr});
  endfunction

  function automatic logic [63:0] sq_term(longint d);
    logic [63:0] m;
    m = (d < 0) ? 64'(-d) : 64'(d);
    if (m >> 32) return 64'h1_0000_0000_0000;
    return (m * m) >> 16;
  endfunction

  // applies one accepted word to the predictor
  function automatic void predict_word(word_t w);
    longint x, y, z;
    logic [63:0] e;
    score_t s;
    if (w.op == OP_LOAD) begin
      if (w.idx < 9) rot[w.idx] = longint'(w.pv);
      else if (w.idx < 12) trn[w.idx-9] = longint'(w.pv);
      return;
    end
    x = cam_row(0, w.px, w.py, w.pz);
    y = cam_row(1, w.px, w.py, w.pz);
    z = cam_row(2, w.px, w.py, w.pz);
    if (z <= 0) begin
      e = {16'd0, ERR_MAX};
      s.is_inlier = 1'b0;
    end else begin
      e = sq_term(longint'(w.u) - project(x, fx, z, cx))
          + sq_term(longint'(w.v) - project(y, fy, z, cy));
      if (e > {16'd0, ERR_MAX}) e = {16'd0, ERR_MAX};
      s.is_inlier = (e[47:0] <= err_lim);
    end
    if (s.is_inlier && inl_cnt < COUNT_CAP) inl_cnt++;
    s.error_sq = e[47:0];
    s.inlier_total = inl_cnt[10:0];
    s.last_result = w.last;
    expected_scores.push_back(s);
    if (w.last) inl_cnt = 0;
  endfunction

  task automatic send_word(word_t w);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= w.op;
    in_ch.pose_index <= w.idx;
    in_ch.pose_value <= w.pv;
    in_ch.point_x    <= w.px;
    in_ch.point_y    <= w.py;
    in_ch.point_z    <= w.pz;
    in_ch.image_u    <= w.u;
    in_ch.image_v    <= w.v;
    in_ch.last_point <= w.last;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(w);
  endtask

  task automatic load_pose(logic [3:0] idx, logic signed [31:0] val);
    word_t w;
    w = '{OP_LOAD, idx, val, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(1)};
    send_word(w);
  endtask

  task automatic score_point(logic signed [31:0] px, py, pz, u, v, logic last);
    word_t w;
    w = '{OP_POINT, 4'($urandom), $urandom, px, py, pz, u, v, last};
    send_word(w);
  endtask

  task automatic set_pose(longint r [9], longint t [3]);
    for (int i = 0; i < 9; i++) load_pose(4'(i), 32'(r[i]));
    for (int i = 0; i < 3; i++) load_pose(4'(9 + i), 32'(t[i]));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_scores.size() != 0) @(negedge clk);
    // a pose load leaves no result behind, so give the core time to settle
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FOCAL_X:  fx = val[31:0];
      CFG_FOCAL_Y:  fy = val[31:0];
      CFG_CENTER_X: cx = val[31:0];
      CFG_CENTER_Y: cy = val[31:0];
      CFG_ERR_LIM:  err_lim = val;
      default: ;
    endcase
  endtask

  task automatic set_camera(logic [31:0] f_x, f_y, c_x, c_y, logic [47:0] lim);
    wait_idle();
    write_reg(CFG_FOCAL_X, {16'd0, f_x});
    write_reg(CFG_FOCAL_Y, {16'd0, f_y});
    write_reg(CFG_CENTER_X, {16'd0, c_x});
    write_reg(CFG_CENTER_Y, {16'd0, c_y});
    write_reg(CFG_ERR_LIM, lim);
  endtask

  // point near the camera; when its depth is positive its match lands close to its projection
  task automatic score_near_point(longint noise, logic last);
    longint px, py, pz, x, y, z, u, v;
    px = longint'($urandom_range(4 * ONE)) - 2 * ONE;
    py = longint'($urandom_range(4 * ONE)) - 2 * ONE;
    pz = longint'($urandom_range(4 * ONE)) - 2 * ONE;
    x = cam_row(0, px, py, pz);
    y = cam_row(1, px, py, pz);
    z = cam_row(2, px, py, pz);
    u = longint'($urandom);
    v = longint'($urandom);
    if (z > 0) begin
      u = project(x, fx, z, cx) + longint'($urandom_range(2 * noise)) - noise;
      v = project(y, fy, z, cy) + longint'($urandom_range(2 * noise)) - noise;
    end
    score_point(32'(px), 32'(py), 32'(pz), 32'(u), 32'(v), last);
  endtask

  task automatic random_pose();
    longint r [9];
    longint t [3];
    for (int i = 0; i < 9; i++)
      r[i] = longint'($urandom_range(16'h4000)) - 16'h2000 + ((i % 4 == 0) ? ONE : 0);
    t[0] = longint'($urandom_range(4 * ONE)) - 2 * ONE;
    t[1] = longint'($urandom_range(4 * ONE)) - 2 * ONE;
    t[2] = longint'($urandom_range(4 * ONE, 10 * ONE));
    set_pose(r, t);
  endtask

  task automatic test_directed();
    longint r [9] = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    longint t [3] = '{0, 0, 5 * ONE};
    set_camera(32'd500 << 16, 32'd400 << 16, 32'd320 << 16, 32'd240 << 16, 48'd25 << 16);
    set_pose(r, t);
    // match lands exactly on the projection, then slightly off
    score_point(0, 0, 0, 32'd320 << 16, 32'd240 << 16, 1'b0);
    score_point(32'sh10000, 32'sh10000, 0, 32'd420 << 16, 32'd320 << 16, 1'b0);
    score_point(0, 0, 0, 32'd324 << 16, 32'd243 << 16, 1'b0);
    // depth not positive
    score_point(0, 0, -32'sd5 << 16, 0, 0, 1'b0);
    score_point(0, 0, 32'h8000_0000, 0, 0, 1'b1);
    // unused pose slots are ignored
    for (int i = 12; i < 16; i++) load_pose(4'(i), 32'h7fff_ffff);
    // field extremes: saturating camera coords, far-off matches
    load_pose(4'd0, 32'h7fff_ffff);
    load_pose(4'd4, 32'h8000_0000);
    score_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    score_point(32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    // zero focal length, max center and threshold, then max focal length
    set_camera(0, 0, 32'hffff_ffff, 32'hffff_ffff, {48{1'b1}});
    score_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h1000, 32'h7fff_ffff, 0, 1'b0);
    set_camera(32'hffff_ffff, 32'hffff_ffff, 0, 0, 0);
    score_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 1'b0);
    score_point(32'h1, 32'h1, 32'h7fff_ffff, 0, 0, 1'b1);
    // writes past the last register index change nothing
    wait_idle();
    for (int i = CFG_ERR_LIM + 1; i < 8; i++) write_reg(CFG_IDX_W'(i), {48{1'b1}});
  endtask

  task automatic test_counter_saturation();
    set_camera(32'd300 << 16, 32'd300 << 16, 32'd200 << 16, 32'd200 << 16, {48{1'b1}});
    random_pose();
    calm = 1'b1;
    for (int i = 0; i < COUNT_CAP + 6; i++) score_near_point(ONE, 1'b0);
    score_near_point(ONE, 1'b1);
    calm = 1'b0;
  endtask

  task automatic test_random();
    int sent = 0;
    while (sent < 400) begin
      if ($urandom_range(9) == 0) begin
        set_camera($urandom_range(1000, 100) << 16, $urandom_range(1000, 100) << 16,
                   $urandom_range(640) << 16, $urandom_range(480) << 16,
                   48'($urandom_range(64)) << 16);
      end
      calm = ($urandom_range(7) == 0);
      if ($urandom_range(4) != 0) begin
        random_pose();
        sent += 12;
        for (int n = $urandom_range(25, 3); n > 0; n--) begin
          score_near_point(longint'($urandom_range(12)) * ONE, n == 1);
          sent++;
        end
      end else begin
        // raw noise: arbitrary loads and points, unmarked or cut short
        for (int n = $urandom_range(8, 1); n > 0; n--) begin
          if ($urandom_range(1)) load_pose(4'($urandom), $urandom);
          else score_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(1));
          sent++;
        end
      end
    end
    calm = 1'b0;
  endtask

  always @(negedge clk)
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);

  always @(posedge clk) begin
    score_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_scores.size() == 0) begin
        $error("unexpected result word: error_sq %h", out_ch.error_sq);
        fails++;
      end else begin
        e = expected_scores.pop_front();
        if (out_ch.is_inlier !== e.is_inlier) begin
          $error("is_inlier: expected %b, got %b", e.is_inlier, out_ch.is_inlier);
          fails++;
        end
        if (out_ch.error_sq !== e.error_sq) begin
          $error("error_sq: expected %h, got %h", e.error_sq, out_ch.error_sq);
          fails++;
        end
        if (out_ch.inlier_total !== e.inlier_total) begin
          $error("inlier_total: expected %0d, got %0d", e.inlier_total, out_ch.inlier_total);
          fails++;
        end
        if (out_ch.last_result !== e.last_result) begin
          $error("last_result: expected %b, got %b", e.last_result, out_ch.last_result);
          fails++;
        end
      end
    end
  end

  // stall watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_LOAD;
    in_ch.pose_index = '0;
    in_ch.pose_value = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    in_ch.image_u = '0;
    in_ch.image_v = '0;
    in_ch.last_point = 1'b0;
    out_ch.ready = 1'b0;
    foreach (rot[i]) rot[i] = 0;
    foreach (trn[i]) trn[i] = 0;
    inl_cnt = 0;
    fx = '0; fy = '0; cx = '0; cy = '0;
    err_lim = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_counter_saturation();
    test_random();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_scores.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* reprojection_inlier_scoring_core.f */
rtl/core/ris_pkg.sv
rtl/core/ris_if.sv
rtl/core/ris_mul.sv
rtl/core/ris_div.sv
rtl/core/reprojection_inlier_scoring_core.sv
rtl/core/ris_chk.sv
sim/tb_reprojection_inlier_scoring_core.sv
